FILE: src/safs_pkg.sv
// shared types and constants for the sprite animation frame sequencer
// no dependencies
`default_nettype none
package safs_pkg;
    localparam int ANIM_COUNT = 8;
    localparam int MAX_SLOTS  = 32;
    localparam int MAX_SKIP   = 256;
    localparam int AW  = $clog2(ANIM_COUNT);
    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int TW  = $clog2(MAX_SLOTS + 1);
    localparam int KW  = $clog2(MAX_SKIP + 1);
    localparam int TBL_DEPTH = ANIM_COUNT * MAX_SLOTS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int ENTRY_W   = 62;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_TIME  = 2'd2,
        CMD_PAINT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD0, ST_CHK, ST_RDN, ST_WALK, ST_FIN, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input item
        logic wr_slot;
        logic set_total;
        logic rd_cur;    // read current slot
        logic check;     // evaluate first slot (time or paint)
        logic rd_next;
        logic walk;      // evaluate next slot duration
        logic finish;    // commit state, read final slot
        logic emit;      // load output register
    } ctl_t;

    typedef struct packed {
        logic is_time;
        logic is_adv;
        logic restart;
        logic need_walk;
        logic walk_more;
    } sts_t;
endpackage
`default_nettype wire

FILE: src/safs_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none
module safs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: src/safs_ctrl.sv
// controller state machine for the frame sequencer
// depends on safs_pkg
`default_nettype none
module safs_ctrl
    import safs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  sts_t      sts,
    output ctl_t      ctl
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                // write/count finish here; advance reads current slot
                if (!sts.is_adv)
                begin
                    ctl.wr_slot   = 1'b1;
                    ctl.set_total = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.rd_cur = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                ctl.check = 1'b1;
                if (sts.is_time && !sts.restart && sts.need_walk)
                begin
                    state_next = ST_RDN;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RDN:
            begin
                ctl.rd_next = 1'b1;
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                ctl.walk = 1'b1;
                state_next = sts.walk_more ? ST_RDN : ST_FIN;
            end
            ST_FIN:
            begin
                ctl.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ctl.emit   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/safs_dp.sv
// datapath: slot table, playback state, skip walk and output register
// depends on safs_pkg and safs_ram
`default_nettype none
module safs_dp
    import safs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  ctl_t             ctl,
    output sts_t             sts,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  anim_index,
    input  wire logic [4:0]  slot_index,
    input  wire logic [14:0] entry_frame,
    input  wire logic [15:0] entry_dx,
    input  wire logic [15:0] entry_dy,
    input  wire logic [14:0] entry_duration,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [31:0] now_ms,
    input  wire logic [1:0]  h_anchor,
    input  wire logic [1:0]  v_anchor,
    output logic [14:0]      frame_id,
    output logic [16:0]      draw_x,
    output logic [16:0]      draw_y,
    output logic [1:0]       h_anchor_out,
    output logic [1:0]       v_anchor_out,
    output logic [4:0]       slot_now
);
    // captured item
    cmd_t        cmd_reg;
    logic [2:0]  anim_reg;
    logic [4:0]  slot_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [15:0] px_reg, py_reg;
    logic [31:0] now_reg;
    logic [1:0]  ah_reg, av_reg;

    // playback state
    logic [TW-1:0] total_reg [ANIM_COUNT];
    logic [SW-1:0] cur_reg   [ANIM_COUNT];
    logic [31:0]   last_reg  [ANIM_COUNT];
    logic [15:0]   paint_reg [ANIM_COUNT];

    // walk registers
    logic [31:0]   elapsed_reg;
    logic [32:0]   sum_reg;
    logic [SW-1:0] nxt_reg, fin_reg;
    logic [SW-1:0] cmod_reg;
    logic [KW-1:0] steps_reg;
    logic          valid_anim;

    // marks that a skip walk ran (slot may wrap back to the same index)
    logic walked_reg;

    logic               ram_we;
    logic [TBL_AW-1:0]  ram_addr;
    logic [SW-1:0]      ram_slot;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [14:0]        rd_dur;

    assign valid_anim = ({1'b0, anim_reg} < (AW+1)'(ANIM_COUNT));
    assign rd_dur     = ram_rdata[14:0];

    logic [TW-1:0] n;
    logic [SW-1:0] cur;
    assign n   = total_reg[anim_reg[AW-1:0]];
    assign cur = cur_reg[anim_reg[AW-1:0]];

    // (x + 1) mod n, x < n
    function automatic logic [SW-1:0] inc_mod(input logic [SW-1:0] x, input logic [TW-1:0] nn);
        logic [SW:0] t;
        t = {1'b0, x} + 1'b1;
        if ((SW+1)'(t) >= (SW+1)'(nn))
            t = '0;
        return t[SW-1:0];
    endfunction

    // x mod n by shift and subtract; the stored slot may exceed a reduced count
    function automatic logic [SW-1:0] mod_n(input logic [SW-1:0] x, input logic [TW-1:0] nn);
        logic [SW+TW-1:0] r;
        r = {{TW{1'b0}}, x};
        for (int k = SW-1; k >= 0; k--)
        begin
            if (r >= ({{SW{1'b0}}, nn} << k))
                r = r - ({{SW{1'b0}}, nn} << k);
        end
        return r[SW-1:0];
    endfunction

    // final slot stays addressed so the read data holds while the output waits
    always_comb
    begin
        ram_slot = fin_reg;
        if (ctl.wr_slot)
            ram_slot = slot_reg[SW-1:0];
        else if (ctl.rd_cur)
            ram_slot = cur;
        else if (ctl.rd_next)
            ram_slot = nxt_reg;
    end
    assign ram_we   = ctl.wr_slot && cmd_reg == CMD_WRITE && valid_anim
                      && ({1'b0, slot_reg} < 6'(MAX_SLOTS));
    assign ram_addr = TBL_AW'({anim_reg[AW-1:0], ram_slot});

    safs_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (entry_reg),
        .rdata (ram_rdata)
    );

    logic [32:0] try_sum;
    assign try_sum = sum_reg + 33'(rd_dur);

    assign sts.is_time   = (cmd_reg == CMD_TIME);
    assign sts.is_adv    = valid_anim && (cmd_reg == CMD_TIME || cmd_reg == CMD_PAINT);
    assign sts.restart   = (last_reg[anim_reg[AW-1:0]] == 32'd0);
    assign sts.need_walk = ((now_reg - last_reg[anim_reg[AW-1:0]]) > 32'(rd_dur))
                           && (KW'(MAX_SKIP) != '0);
    assign sts.walk_more = (try_sum < {1'b0, elapsed_reg})
                           && (steps_reg + 1'b1 < KW'(MAX_SKIP));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(command);
            anim_reg  <= anim_index;
            slot_reg  <= slot_index;
            entry_reg <= {entry_frame, entry_dx, entry_dy, entry_duration};
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            now_reg   <= now_ms;
            ah_reg    <= h_anchor;
            av_reg    <= v_anchor;
        end
        if (ctl.rd_cur)
            cmod_reg <= mod_n(cur, n);
        if (ctl.check)
        begin
            elapsed_reg <= now_reg - last_reg[anim_reg[AW-1:0]];
            sum_reg     <= 33'(rd_dur);
            nxt_reg     <= inc_mod(cmod_reg, n);
            steps_reg   <= '0;
            fin_reg     <= cmod_reg;
            if (sts.is_time)
            begin
                if (sts.restart)
                    fin_reg <= '0;
                else if (sts.need_walk)
                    fin_reg <= inc_mod(cmod_reg, n);
            end
            else if ({1'b0, paint_reg[anim_reg[AW-1:0]]} >= 17'(rd_dur))
            begin
                fin_reg <= inc_mod(cmod_reg, n);
            end
        end
        if (ctl.walk)
        begin
            if (try_sum < {1'b0, elapsed_reg})
            begin
                sum_reg   <= try_sum;
                nxt_reg   <= inc_mod(nxt_reg, n);
                fin_reg   <= inc_mod(nxt_reg, n);
                steps_reg <= steps_reg + 1'b1;
            end
        end
        if (ctl.emit)
        begin
            frame_id     <= ram_rdata[61:47];
            draw_x       <= {px_reg[15], px_reg} + {ram_rdata[46], ram_rdata[46:31]};
            draw_y       <= {py_reg[15], py_reg} + {ram_rdata[30], ram_rdata[30:15]};
            h_anchor_out <= ah_reg;
            v_anchor_out <= av_reg;
            slot_now     <= 5'(fin_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ANIM_COUNT; i++)
            begin
                total_reg[i] <= TW'(1);
                cur_reg[i]   <= '0;
                last_reg[i]  <= '0;
                paint_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.set_total && cmd_reg == CMD_COUNT && valid_anim)
                total_reg[anim_reg[AW-1:0]] <= TW'(slot_reg) + 1'b1;
            if (ctl.check)
            begin
                if (sts.is_time)
                begin
                    if (sts.restart)
                        last_reg[anim_reg[AW-1:0]] <= now_reg;
                end
                else if ({1'b0, paint_reg[anim_reg[AW-1:0]]} >= 17'(rd_dur))
                    paint_reg[anim_reg[AW-1:0]] <= 16'd1;
                else
                    paint_reg[anim_reg[AW-1:0]] <= paint_reg[anim_reg[AW-1:0]] + 1'b1;
            end
            if (ctl.finish)
            begin
                cur_reg[anim_reg[AW-1:0]] <= fin_reg;
                if (walked_reg)
                    last_reg[anim_reg[AW-1:0]] <= last_reg[anim_reg[AW-1:0]] + sum_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walked_reg <= 1'b0;
        else if (ctl.check)
            walked_reg <= sts.is_time && !sts.restart && sts.need_walk;
    end
endmodule
`default_nettype wire

FILE: src/sprite_anim_frame_sequencer.sv
// top level of the sprite animation frame sequencer
// depends on safs_pkg, safs_ctrl, safs_dp, safs_ram
// One item at a time. Slot writes and frame count commands finish in the
// RD0 state; advance commands read the current slot, check it, walk the
// slot durations for a time command (at most MAX_SKIP reads of the single
// port slot table, whose read data is registered), then finish. The result
// sits in an output register; an advance waits in ST_OUT while an
// earlier result is still stalled, and a new item is taken once its result is loaded.
`default_nettype none
module sprite_anim_frame_sequencer
    import safs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  anim_index,
    input  wire logic [4:0]  slot_index,
    input  wire logic [14:0] entry_frame,
    input  wire logic [15:0] entry_dx,
    input  wire logic [15:0] entry_dy,
    input  wire logic [14:0] entry_duration,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [31:0] now_ms,
    input  wire logic [1:0]  h_anchor,
    input  wire logic [1:0]  v_anchor,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [14:0]      frame_id,
    output logic [16:0]      draw_x,
    output logic [16:0]      draw_y,
    output logic [1:0]       h_anchor_out,
    output logic [1:0]       v_anchor_out,
    output logic [4:0]       slot_now
);
    ctl_t ctl;
    sts_t sts;

    safs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
    );

    safs_dp u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .command(command), .anim_index(anim_index), .slot_index(slot_index),
        .entry_frame(entry_frame), .entry_dx(entry_dx), .entry_dy(entry_dy),
        .entry_duration(entry_duration), .pos_x(pos_x), .pos_y(pos_y),
        .now_ms(now_ms), .h_anchor(h_anchor), .v_anchor(v_anchor),
        .frame_id(frame_id), .draw_x(draw_x), .draw_y(draw_y),
        .h_anchor_out(h_anchor_out), .v_anchor_out(v_anchor_out),
        .slot_now(slot_now)
    );

`ifndef SYNTH
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.check, ctl.walk, ctl.finish, ctl.emit}))
        else $error("more than one step active");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> !(out_valid && out_stall))
        else $error("output overwritten while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> in_stall)
        else $error("input taken while busy");
`endif
endmodule
`default_nettype wire
